@@ hdl/sfpa_pkg.sv @@
// sfpa_pkg: shared constants and stage types for the 16-bit float adder.
// No dependencies.
package sfpa_pkg;
	localparam logic [15:0] NAN_CODE = 16'h7f01;
	localparam logic [15:0] POS_INF  = 16'h7f00;
	localparam logic [15:0] NEG_INF  = 16'hff00;
	localparam int          EXP_BIAS = 63;
	localparam logic [6:0]  MAX_ALIGN = 7'd15;

	// stage 1 -> 2: swapped, aligned operands
	typedef struct packed {
		logic        special;
		logic [15:0] special_val;
		logic        sa;
		logic        sub;
		logic [6:0]  ex;
		logic [11:0] mx;
		logic [11:0] my;
	} sfpa_align_t;

	// stage 2 -> 3: normalized, unrounded
	typedef struct packed {
		logic        special;
		logic [15:0] special_val;
		logic        sa;
		logic        sub;
		logic [7:0]  eb;   // biased exponent, may reach 127+
		logic [12:0] m;
	} sfpa_norm_t;
endpackage

@@ hdl/sfpa_if.sv @@
// sfpa_if: valid/ready channels carrying the adder's input operands and output sum.
// Depends on nothing.
interface sfpa_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] addend_a;
	logic [15:0] addend_b;
	modport source (output valid, addend_a, addend_b, input ready);
	modport sink   (input valid, addend_a, addend_b, output ready);
endinterface

interface sfpa_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] sum_value;
	modport source (output valid, sum_value, input ready);
	modport sink   (input valid, sum_value, output ready);
endinterface

@@ hdl/sfpa_align.sv @@
// sfpa_align: special cases, swap and alignment (combinational, stage 1 logic).
// Depends on sfpa_pkg.
module sfpa_align import sfpa_pkg::*; (
	input  logic [15:0] a_in,
	input  logic [15:0] b_in,
	output sfpa_align_t res
);
	logic        nan_a, nan_b, inf_a, inf_b, swp;
	logic [15:0] a, b;
	logic [6:0]  ea, eb, ex, ey, diff;
	logic [11:0] mx, my0;
	logic [15:0] msk;
	logic        stk;

	always_comb begin
		nan_a = (a_in[14:8] == 7'h7f) && (a_in[7:0] != 8'd0);
		nan_b = (b_in[14:8] == 7'h7f) && (b_in[7:0] != 8'd0);
		inf_a = a_in[14:0] == 15'h7f00;
		inf_b = b_in[14:0] == 15'h7f00;
		swp = b_in[14:0] > a_in[14:0];
		a = swp ? b_in : a_in;
		b = swp ? a_in : b_in;
		ea = a[14:8];
		eb = b[14:8];
		ex = (ea != 7'd0) ? ea : 7'd1;
		ey = (eb != 7'd0) ? eb : 7'd1;
		diff = ex - ey;
		mx = {(ea != 7'd0), a[7:0], 3'b000};
		my0 = {(eb != 7'd0), b[7:0], 3'b000};
		// sticky covers bits 0..diff of the unshifted operand
		msk = ~(16'hffff << ({1'b0, diff[3:0]} + 5'd1));
		stk = ({4'd0, my0} & msk) != 16'd0;
		res.special = 1'b0;
		res.special_val = a;
		if (nan_a || nan_b) begin
			res.special = 1'b1;
			res.special_val = NAN_CODE;
		end else if (inf_a || inf_b) begin
			res.special = 1'b1;
			if (inf_a && inf_b && (a_in[15] != b_in[15]))
				res.special_val = NAN_CODE;
			else
				res.special_val = inf_a ? a_in : b_in;
		end else if (diff > MAX_ALIGN) begin
			res.special = 1'b1;
			res.special_val = a;
		end
		res.sa = a[15];
		res.sub = a[15] ^ b[15];
		res.ex = ex;
		res.mx = mx;
		res.my = (my0 >> diff[3:0]) | {11'd0, stk};
	end
endmodule

@@ hdl/sfpa_norm.sv @@
// sfpa_norm: add/subtract and normalize (combinational, stage 2 logic).
// Depends on sfpa_pkg.
module sfpa_norm import sfpa_pkg::*; (
	input  sfpa_align_t op,
	output sfpa_norm_t  res
);
	logic [12:0] m;
	logic [3:0]  lz, sh;
	logic [7:0]  room;

	always_comb begin
		m = op.sub ? ({1'b0, op.mx} - {1'b0, op.my}) : ({1'b0, op.mx} + {1'b0, op.my});
		lz = 4'd0;
		for (int i = 0; i <= 10; i++)
			if (m[i]) lz = 4'(11 - i);
		room = {1'b0, op.ex} - 8'd1;
		sh = lz;
		res.special = op.special;
		res.special_val = op.special_val;
		res.sa = op.sa;
		res.sub = op.sub;
		res.eb = {1'b0, op.ex};
		res.m = m;
		if (m[12]) begin
			res.m = {1'b0, m[12:2], m[1] | m[0]};
			res.eb = {1'b0, op.ex} + 8'd1;
		end else if (m != 13'd0 && !m[11]) begin
			sh = ({4'd0, lz} > room) ? room[3:0] : lz;
			res.m = m << sh;
			res.eb = {1'b0, op.ex} - {4'd0, sh};
		end
	end
endmodule

@@ hdl/sfpa_round.sv @@
// sfpa_round: round to nearest even, renormalize and pack (stage 3 logic).
// Depends on sfpa_pkg.
module sfpa_round import sfpa_pkg::*; (
	input  sfpa_norm_t  op,
	output logic [15:0] sum
);
	logic [9:0] m;
	logic [7:0] e;
	logic       up;

	always_comb begin
		up = op.m[2] && ((op.m[1:0] != 2'd0) || op.m[3]);
		m = {1'b0, op.m[11:3]} + {9'd0, up};
		e = op.eb;
		if (m[9]) begin
			m = m >> 1;
			e = e + 8'd1;
		end
		if (op.special)
			sum = op.special_val;
		else if (e >= 8'd127)
			sum = op.sa ? NEG_INF : POS_INF;
		else if (m == 10'd0)
			sum = op.sub ? 16'd0 : {op.sa, 15'd0};
		else
			sum = {op.sa, (m[8] ? e[6:0] : 7'd0), m[7:0]};
	end
endmodule

@@ hdl/sfp16_float_adder_unit.sv @@
// Channel | Dir | Payload
// in      | in  | addend_a[15:0], addend_b[15:0]
// out     | out | sum_value[15:0]
// Three-stage pipeline: align, add/normalize, round. Accepts one
// transaction per cycle while out is not stalled. Reset clears valid bits only.
// A stall holds only valid stages whose next stage is held; a bubble is filled while out waits.
// Depends on sfpa_pkg, sfpa_if, sfpa_align, sfpa_norm, sfpa_round.
module sfp16_float_adder_unit import sfpa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sfpa_in_if.sink    in_ch,
	sfpa_out_if.source out_ch
);
	sfpa_align_t al_c, al_s1;
	sfpa_norm_t  nm_c, nm_s2;
	logic [15:0] sum_c, sum_s3;
	logic        v_s1, v_s2, v_s3, en1, en2, en3;

	assign en3 = !v_s3 || out_ch.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	sfpa_align u_al (.a_in(in_ch.addend_a), .b_in(in_ch.addend_b), .res(al_c));
	sfpa_norm  u_nm (.op(al_s1), .res(nm_c));
	sfpa_round u_rd (.op(nm_s2), .sum(sum_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) al_s1 <= al_c;
		if (en2) nm_s2 <= nm_c;
		if (en3) sum_s3 <= sum_c;
	end

	assign out_ch.valid = v_s3;
	assign out_ch.sum_value = sum_s3;
endmodule

@@ hdl/sfpa_checker.sv @@
// sfpa_checker: port-level assertions for sfp16_float_adder_unit, with bind.
// Depends on sfp16_float_adder_unit (bind target).
module sfpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_sum
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sum)) else $error("out hold");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("ready blocked");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("latency");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sum[14:8] == 7'h7f && out_sum[7:0] != 8'd0 |-> out_sum == 16'h7f01)
		else $error("nan code");
endmodule

bind sfp16_float_adder_unit sfpa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_sum(out_ch.sum_value));
